[hdl/lbx_pkg.sv]
// shared types and constants for the letterbox rectangle and pointer map
package lbx_pkg;
	localparam int DIM_BITS = 12;
	localparam int RECT_W = DIM_BITS + 2;
	localparam int DVD_W = 2 * DIM_BITS + 2;
	localparam int DSR_W = RECT_W;
	localparam int CNT_W = $clog2(DVD_W);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [2:0] REG_WIN_W = 3'd0;
	localparam logic [2:0] REG_WIN_H = 3'd1;
	localparam logic [2:0] REG_CON_W = 3'd2;
	localparam logic [2:0] REG_CON_H = 3'd3;
	localparam logic [2:0] REG_MODE = 3'd4;
	localparam logic [2:0] REG_WHOLE = 3'd5;

	localparam logic [2:0] MODE_FIT = 3'd4;

	typedef struct packed {
		logic signed [RECT_W-1:0] left;
		logic signed [RECT_W-1:0] top;
		logic [RECT_W-1:0] w;
		logic [RECT_W-1:0] h;
		logic [DIM_BITS-1:0] cw;
		logic [DIM_BITS-1:0] ch;
		logic ready;
	} geom_t;

	typedef struct packed {
		logic [RECT_W-1:0] dx;
		logic [RECT_W-1:0] dy;
		logic hit;
	} ptr_t;
endpackage

[hdl/lbx_div.sv]
// iterative restoring divider, one quotient bit per cycle
module lbx_div
	import lbx_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DVD_W-1:0] dividend,
	input logic [DSR_W-1:0] divisor,
	output logic done,
	output logic [DVD_W-1:0] quotient
);
	logic active_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W:0] trial;
	logic [DSR_W:0] diff;
	logic ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge = trial >= {1'b0, dsr_q};
	assign diff = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					active_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (active_q) begin
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;
endmodule

[hdl/lbx_geom.sv]
// configuration registers and presentation rectangle sequencer
module lbx_geom
	import lbx_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [2:0] wr_idx,
	input logic [DIM_BITS-1:0] wr_data,
	output geom_t geom
);
	typedef enum logic [2:0] {G_IDLE, G_START, G_WAIT, G_SIZE, G_EDGE} gstate_t;

	logic [DIM_BITS-1:0] ww_q, wh_q, cw_q, ch_q;
	logic [2:0] mode_q;
	logic whole_q;
	logic dirty_q;
	gstate_t state_q;
	logic [1:0] job_q;
	logic [DVD_W-1:0] q0_q;
	logic [DIM_BITS-1:0] q1_q, q2_q, q3_q;
	logic [RECT_W-1:0] w_q, h_q;
	logic signed [RECT_W-1:0] left_q, top_q;

	logic [DIM_BITS-1:0] ww1, wh1, cw1, ch1;
	logic div_start, div_done;
	logic [DVD_W-1:0] div_dvd, div_quo;
	logic [DSR_W-1:0] div_dsr;
	logic [DIM_BITS-1:0] mul_a, mul_b, div_by;
	logic [2*DIM_BITS-1:0] prod;
	logic [DIM_BITS-1:0] k, kmin;
	logic [2*DIM_BITS-1:0] kw_prod, kh_prod;
	logic [DIM_BITS-1:0] fit_w, fit_h;
	logic [RECT_W:0] fix_w, fix_h;
	logic [RECT_W-1:0] w_n, h_n;
	logic [RECT_W:0] dw, dh, dw_adj, dh_adj;

	assign ww1 = (ww_q == '0) ? DIM_BITS'(1) : ww_q;
	assign wh1 = (wh_q == '0) ? DIM_BITS'(1) : wh_q;
	assign cw1 = (cw_q == '0) ? DIM_BITS'(1) : cw_q;
	assign ch1 = (ch_q == '0) ? DIM_BITS'(1) : ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ww_q <= DIM_BITS'(320);
			wh_q <= DIM_BITS'(200);
			cw_q <= DIM_BITS'(320);
			ch_q <= DIM_BITS'(200);
			mode_q <= MODE_FIT;
			whole_q <= 1'b1;
		end else if (wr_en) begin
			case (wr_idx)
				REG_WIN_W: ww_q <= wr_data;
				REG_WIN_H: wh_q <= wr_data;
				REG_CON_W: cw_q <= wr_data;
				REG_CON_H: ch_q <= wr_data;
				REG_MODE: mode_q <= wr_data[2:0];
				REG_WHOLE: whole_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// fit height, fit width, whole factors per axis
	always_comb begin
		case (job_q)
			2'd0: begin mul_a = ww1; mul_b = ch1; div_by = cw1; end
			2'd1: begin mul_a = wh1; mul_b = cw1; div_by = ch1; end
			2'd2: begin mul_a = ww1; mul_b = DIM_BITS'(1); div_by = cw1; end
			default: begin mul_a = wh1; mul_b = DIM_BITS'(1); div_by = ch1; end
		endcase
	end

	assign prod = (2*DIM_BITS)'(mul_a) * (2*DIM_BITS)'(mul_b);
	assign div_dvd = DVD_W'(prod);
	assign div_dsr = DSR_W'(div_by);
	assign div_start = (state_q == G_START);

	lbx_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dsr),
		.done(div_done),
		.quotient(div_quo)
	);

	always_comb begin
		kmin = (q2_q < q3_q) ? q2_q : q3_q;
		k = (kmin == '0) ? DIM_BITS'(1) : kmin;
		kw_prod = (2*DIM_BITS)'(cw1) * (2*DIM_BITS)'(k);
		kh_prod = (2*DIM_BITS)'(ch1) * (2*DIM_BITS)'(k);
		if (q0_q > DVD_W'(wh1)) begin
			fit_w = q1_q;
			fit_h = wh1;
		end else begin
			fit_w = ww1;
			fit_h = q0_q[DIM_BITS-1:0];
		end
		if (whole_q) begin
			fit_w = kw_prod[DIM_BITS-1:0];
			fit_h = kh_prod[DIM_BITS-1:0];
		end
		if (fit_w == '0) fit_w = DIM_BITS'(1);
		if (fit_h == '0) fit_h = DIM_BITS'(1);
		fix_w = (RECT_W+1)'(cw1) * (RECT_W+1)'({1'b0, mode_q[1:0]} + 3'd1);
		fix_h = (RECT_W+1)'(ch1) * (RECT_W+1)'({1'b0, mode_q[1:0]} + 3'd1);
		if (mode_q[2] == 1'b0) begin
			w_n = fix_w[RECT_W-1:0];
			h_n = fix_h[RECT_W-1:0];
		end else if (mode_q == MODE_FIT) begin
			w_n = RECT_W'(fit_w);
			h_n = RECT_W'(fit_h);
		end else begin
			w_n = RECT_W'(ww1);
			h_n = RECT_W'(wh1);
		end
		dw = {3'b000, ww1} - {1'b0, w_q};
		dh = {3'b000, wh1} - {1'b0, h_q};
		dw_adj = dw + {{RECT_W{1'b0}}, dw[RECT_W]};
		dh_adj = dh + {{RECT_W{1'b0}}, dh[RECT_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			dirty_q <= 1'b1;
			job_q <= '0;
		end else begin
			dirty_q <= wr_en | (dirty_q & (state_q != G_IDLE));
			case (state_q)
				G_IDLE: begin
					if (dirty_q) begin
						job_q <= '0;
						state_q <= G_START;
					end
				end
				G_START: state_q <= G_WAIT;
				G_WAIT: begin
					if (div_done) begin
						case (job_q)
							2'd0: q0_q <= div_quo;
							2'd1: q1_q <= div_quo[DIM_BITS-1:0];
							2'd2: q2_q <= div_quo[DIM_BITS-1:0];
							default: q3_q <= div_quo[DIM_BITS-1:0];
						endcase
						job_q <= job_q + 2'd1;
						state_q <= (job_q == 2'd3) ? G_SIZE : G_START;
					end
				end
				G_SIZE: begin
					w_q <= w_n;
					h_q <= h_n;
					state_q <= G_EDGE;
				end
				G_EDGE: begin
					left_q <= dw_adj[RECT_W:1];
					top_q <= dh_adj[RECT_W:1];
					state_q <= G_IDLE;
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	assign geom.left = left_q;
	assign geom.top = top_q;
	assign geom.w = w_q;
	assign geom.h = h_q;
	assign geom.cw = cw1;
	assign geom.ch = ch1;
	assign geom.ready = (state_q == G_IDLE) && !dirty_q;
endmodule

[hdl/lbx_front.sv]
// input stage: rectangle hit test and beat queue toward the mapper
module lbx_front
	import lbx_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [DIM_BITS-1:0] pointer_x,
	input logic [DIM_BITS-1:0] pointer_y,
	input geom_t geom,
	input logic rd,
	output logic avail,
	output ptr_t entry
);
	ptr_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_AW:0] cnt_q;
	logic [RECT_W:0] dx, dy;
	logic do_push, do_pop;
	ptr_t wr_ent;

	assign dx = {3'b000, pointer_x} - {geom.left[RECT_W-1], geom.left};
	assign dy = {3'b000, pointer_y} - {geom.top[RECT_W-1], geom.top};

	always_comb begin
		wr_ent.dx = dx[RECT_W-1:0];
		wr_ent.dy = dy[RECT_W-1:0];
		wr_ent.hit = !dx[RECT_W] && !dy[RECT_W] && (dx < {1'b0, geom.w})
			&& (dy < {1'b0, geom.h});
	end

	assign full = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH)) || !geom.ready;
	assign avail = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop = rd && avail;
	assign entry = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + FIFO_AW'(1);
			if (do_pop) rp_q <= rp_q + FIFO_AW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + (FIFO_AW+1)'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - (FIFO_AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wr_ent;
	end
endmodule

[hdl/lbx_back.sv]
// mapper: scales the offset into content pixels and holds the result beat
module lbx_back
	import lbx_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input geom_t geom,
	input logic avail,
	input ptr_t entry,
	output logic rd,
	output logic empty,
	input logic pop,
	output logic inside_res,
	output logic [DIM_BITS-1:0] content_x,
	output logic [DIM_BITS-1:0] content_y
);
	typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} bstate_t;

	bstate_t state_q;
	logic res_in_q;
	logic [DIM_BITS-1:0] res_cx_q, res_cy_q;
	logic out_v_q;
	logic out_in_q;
	logic [DIM_BITS-1:0] out_cx_q, out_cy_q;
	logic start;
	logic [DVD_W-1:0] dvd_x, dvd_y, quo_x, quo_y;
	logic done_x, done_y;
	logic [DIM_BITS-1:0] cx_n, cy_n;
	logic load;

	assign rd = (state_q == B_IDLE) && avail;
	assign start = rd && entry.hit;
	assign dvd_x = DVD_W'(entry.dx) * DVD_W'(geom.cw);
	assign dvd_y = DVD_W'(entry.dy) * DVD_W'(geom.ch);

	lbx_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(start), .dividend(dvd_x),
		.divisor(geom.w), .done(done_x), .quotient(quo_x)
	);

	lbx_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(start), .dividend(dvd_y),
		.divisor(geom.h), .done(done_y), .quotient(quo_y)
	);

	assign cx_n = (quo_x >= DVD_W'(geom.cw)) ? geom.cw - DIM_BITS'(1) : quo_x[DIM_BITS-1:0];
	assign cy_n = (quo_y >= DVD_W'(geom.ch)) ? geom.ch - DIM_BITS'(1) : quo_y[DIM_BITS-1:0];
	assign load = (state_q == B_OUT) && (!out_v_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_v_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (rd) begin
						res_in_q <= entry.hit;
						res_cx_q <= '0;
						res_cy_q <= '0;
						state_q <= entry.hit ? B_DIV : B_OUT;
					end
				end
				B_DIV: begin
					if (done_x && done_y) begin
						res_cx_q <= cx_n;
						res_cy_q <= cy_n;
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (load) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
			if (load) begin
				out_v_q <= 1'b1;
				out_in_q <= res_in_q;
				out_cx_q <= res_cx_q;
				out_cy_q <= res_cy_q;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign empty = !out_v_q;
	assign inside_res = out_in_q;
	assign content_x = out_cx_q;
	assign content_y = out_cy_q;
endmodule

[hdl/letterbox_rect_and_pointer_map.sv]
// top level of the letterbox rectangle and pointer map
//
// input queue: push with pointer_x/pointer_y, accepted when push is high and
// full is low. result queue: while empty is low the oldest result sits on
// inside_res and content_x/content_y; pop takes it.
// registers are written through wr_en/wr_idx/wr_data, one per cycle.
// after reset or any register write the rectangle is rebuilt by one shared
// 26-step divider over four quotients; full stays high until the rebuild
// ends. rect_* follow the registers. a pointer outside the rectangle skips
// the dividers; one inside has its offset scaled by the pair of 26-step
// dividers. the mapper works one beat at a time and takes no new beat until
// its result has moved on to the output register. a four-beat queue sits in
// front of the mapper and an output register behind it, so new beats are
// taken while a result waits. when pop is held low the result holds, the
// mapper parks its next result, and full rises once the queue fills.
module letterbox_rect_and_pointer_map
	import lbx_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [2:0] wr_idx,
	input logic [DIM_BITS-1:0] wr_data,
	input logic push,
	output logic full,
	input logic [DIM_BITS-1:0] pointer_x,
	input logic [DIM_BITS-1:0] pointer_y,
	output logic empty,
	input logic pop,
	output logic signed [RECT_W-1:0] rect_left,
	output logic signed [RECT_W-1:0] rect_top,
	output logic [RECT_W-1:0] rect_width,
	output logic [RECT_W-1:0] rect_height,
	output logic inside_res,
	output logic [DIM_BITS-1:0] content_x,
	output logic [DIM_BITS-1:0] content_y
);
	geom_t geom;
	ptr_t entry;
	logic rd, avail;

	lbx_geom u_geom (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_idx(wr_idx),
		.wr_data(wr_data), .geom(geom)
	);

	lbx_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.pointer_x(pointer_x), .pointer_y(pointer_y), .geom(geom),
		.rd(rd), .avail(avail), .entry(entry)
	);

	lbx_back u_back (
		.clk(clk), .arst_n(arst_n), .geom(geom), .avail(avail), .entry(entry),
		.rd(rd), .empty(empty), .pop(pop), .inside_res(inside_res),
		.content_x(content_x), .content_y(content_y)
	);

	assign rect_left = geom.left;
	assign rect_top = geom.top;
	assign rect_width = geom.w;
	assign rect_height = geom.h;
endmodule

[hdl/lbx_chk.sv]
// port checker for the letterbox rectangle and pointer map
module lbx_chk
	import lbx_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic [RECT_W-1:0] rect_width,
	input logic [RECT_W-1:0] rect_height,
	input logic inside_res,
	input logic [DIM_BITS-1:0] content_x,
	input logic [DIM_BITS-1:0] content_y
);
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !inside_res) |-> (content_x == '0 && content_y == '0))
		else $error("outside beat carries a content pixel");

	a_rect_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (rect_width != '0 && rect_height != '0))
		else $error("empty rectangle with a result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(inside_res) && $stable(content_x)
			&& $stable(content_y)))
		else $error("stalled result beat changed");
endmodule

bind letterbox_rect_and_pointer_map lbx_chk u_chk (.*);
